### src/bsep_pkg.sv
// Shared types and constants for the booster separation sequencer.
package bsep_pkg;

	// Sequence timing and thresholds.
	localparam logic [31:0] START_MS  = 32'd100000;
	localparam logic [9:0]  CUE_PSI   = 10'd50;
	localparam logic [31:0] HOLD_MS   = 32'd4000;
	localparam logic [10:0] QBAR_Q16  = 11'd1369;
	localparam logic [9:0]  MODE_ARM  = 10'd102;
	localparam logic [9:0]  MODE_NEXT = 10'd103;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QBAR_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_CUE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MODING_DLY  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_DLY = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CUE_SPREAD  = 3'd7;
	localparam int unsigned CFG_DATA_W = 24;

	// Configuration register contents.
	typedef struct packed {
		logic [23:0] roll_rate_limit;
		logic [23:0] pitch_rate_limit;
		logic [23:0] yaw_rate_limit;
		logic [16:0] qbar_limit;
		logic [23:0] backup_cue_time;
		logic [15:0] moding_delay;
		logic [15:0] command_delay;
		logic [15:0] max_cue_spread;
	} cfg_t;

	// One input item.
	typedef struct packed {
		logic               action;
		logic [9:0]         new_major_mode;
		logic [31:0]        met_ms;
		logic [9:0]         left_chamber_psi;
		logic [9:0]         right_chamber_psi;
		logic signed [15:0] roll_rate;
		logic signed [15:0] pitch_rate;
		logic signed [15:0] yaw_rate;
		logic [15:0]        dyn_pressure_pa;
		logic               manual_enable;
		logic               manual_initiate;
		logic               meco_confirmed;
	} item_t;

	// One result item.
	typedef struct packed {
		logic seq_active;
		logic pc_cue_flag;
		logic initiated;
		logic pyro_arm;
		logic inhibit_alert;
		logic fire;
		logic sep_commanded;
		logic mode_103_request;
		logic master_reset;
		logic mode_accepted;
	} result_t;

endpackage

### src/bsep_cfg.sv
// Configuration register file for the booster separation sequencer.
module bsep_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [bsep_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [bsep_pkg::CFG_DATA_W-1:0]     wr_data,
	output bsep_pkg::cfg_t                      cfg
);
	import bsep_pkg::*;

	cfg_t cfg_q;

	// Register writes, one register per write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roll_rate_limit  <= 24'd9999900;
			cfg_q.pitch_rate_limit <= 24'd9999900;
			cfg_q.yaw_rate_limit   <= 24'd9999900;
			cfg_q.qbar_limit       <= 17'd99999;
			cfg_q.backup_cue_time  <= 24'd131280;
			cfg_q.moding_delay     <= 16'd3200;
			cfg_q.command_delay    <= 16'd4900;
			cfg_q.max_cue_spread   <= 16'd5500;
		end else if (wr_en) begin
			case (wr_index)
				CFG_ROLL_LIMIT:  cfg_q.roll_rate_limit  <= wr_data;
				CFG_PITCH_LIMIT: cfg_q.pitch_rate_limit <= wr_data;
				CFG_YAW_LIMIT:   cfg_q.yaw_rate_limit   <= wr_data;
				CFG_QBAR_LIMIT:  cfg_q.qbar_limit       <= wr_data[16:0];
				CFG_BACKUP_CUE:  cfg_q.backup_cue_time  <= wr_data;
				CFG_MODING_DLY:  cfg_q.moding_delay     <= wr_data[15:0];
				CFG_COMMAND_DLY: cfg_q.command_delay    <= wr_data[15:0];
				CFG_CUE_SPREAD:  cfg_q.max_cue_spread   <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/bsep_seq.sv
// Sequence state registers and the per-item step logic.
module bsep_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  bsep_pkg::item_t   item,
	input  bsep_pkg::cfg_t    cfg,
	output bsep_pkg::result_t res
);
	import bsep_pkg::*;

	// Sequence state.
	logic        armed_q, init_latched_q, cmd_latched_q, cue_latched_q, alert_latched_q;
	logic        left_cue_valid_q, right_cue_valid_q, deadlines_set_q;
	logic        fire_started_q, hold_passed_q;
	logic [31:0] left_cue_time_q, right_cue_time_q;
	logic [31:0] moding_deadline_q, command_deadline_q, fire_start_time_q;

	logic        armed_d, init_latched_d, cmd_latched_d, cue_latched_d, alert_latched_d;
	logic        left_cue_valid_d, right_cue_valid_d, deadlines_set_d;
	logic        fire_started_d, hold_passed_d;
	logic [31:0] left_cue_time_d, right_cue_time_d;
	logic [31:0] moding_deadline_d, command_deadline_d, fire_start_time_d;

	// Saturating deadline sums.
	logic [32:0] moding_sum, command_sum;
	logic [31:0] moding_sat, command_sat;

	assign moding_sum  = {1'b0, item.met_ms} + {17'd0, cfg.moding_delay};
	assign command_sum = {1'b0, item.met_ms} + {17'd0, cfg.command_delay};
	assign moding_sat  = moding_sum[32] ? 32'hFFFF_FFFF : moding_sum[31:0];
	assign command_sat = command_sum[32] ? 32'hFFFF_FFFF : command_sum[31:0];

	// Rate magnitudes, 0 to 32768.
	function automatic logic [16:0] rate_mag(input logic [15:0] r);
		return r[15] ? (17'h10000 - {1'b0, r}) : {1'b0, r};
	endfunction

	logic rates_ok, qbar_ok, limits_ok;
	logic [26:0] qbar_prod;

	assign qbar_prod = 27'(item.dyn_pressure_pa) * 27'(QBAR_Q16);
	assign qbar_ok   = {6'd0, qbar_prod} < {cfg.qbar_limit, 16'd0};
	assign rates_ok  = ({7'd0, rate_mag(item.roll_rate)} < cfg.roll_rate_limit) &&
		({7'd0, rate_mag(item.pitch_rate)} < cfg.pitch_rate_limit) &&
		({7'd0, rate_mag(item.yaw_rate)} < cfg.yaw_rate_limit);
	assign limits_ok = rates_ok && qbar_ok;

	logic        tick_run, go_init, go_check, go_fire, pyro, fire, req103, mreset, accepted;
	logic [31:0] cue_gap, moding_eff, command_eff, hold_age;

	assign tick_run = !item.action && armed_q && (item.met_ms >= START_MS);

	// Step logic: mode handling, cue latching, initiation, check, fire and hold.
	always_comb begin
		armed_d            = armed_q;
		init_latched_d     = init_latched_q;
		cmd_latched_d      = cmd_latched_q;
		cue_latched_d      = cue_latched_q;
		alert_latched_d    = alert_latched_q;
		left_cue_valid_d   = left_cue_valid_q;
		right_cue_valid_d  = right_cue_valid_q;
		deadlines_set_d    = deadlines_set_q;
		fire_started_d     = fire_started_q;
		hold_passed_d      = hold_passed_q;
		left_cue_time_d    = left_cue_time_q;
		right_cue_time_d   = right_cue_time_q;
		moding_deadline_d  = moding_deadline_q;
		command_deadline_d = command_deadline_q;
		fire_start_time_d  = fire_start_time_q;
		go_init   = 1'b0;
		go_check  = 1'b0;
		go_fire   = 1'b0;
		pyro      = 1'b0;
		fire      = 1'b0;
		req103    = 1'b0;
		mreset    = 1'b0;
		accepted  = 1'b0;
		cue_gap   = 32'd0;
		hold_age  = 32'd0;
		moding_eff  = deadlines_set_q ? moding_deadline_q : moding_sat;
		command_eff = deadlines_set_q ? command_deadline_q : command_sat;

		if (item.action) begin
			if (item.new_major_mode == MODE_ARM) begin
				armed_d  = 1'b1;
				accepted = 1'b1;
			end else if (item.new_major_mode == MODE_NEXT) begin
				accepted = 1'b1;
			end
		end else if (tick_run) begin
			if (cmd_latched_q) begin
				go_fire = 1'b1;
			end else if (init_latched_q) begin
				go_init = 1'b1;
			end else begin
				// Latch the first low-pressure time on each side.
				if (item.left_chamber_psi < CUE_PSI && !left_cue_valid_q) begin
					left_cue_valid_d = 1'b1;
					left_cue_time_d  = item.met_ms;
				end
				if (item.right_chamber_psi < CUE_PSI && !right_cue_valid_q) begin
					right_cue_valid_d = 1'b1;
					right_cue_time_d  = item.met_ms;
				end
				cue_gap = (left_cue_time_d >= right_cue_time_d) ?
					(left_cue_time_d - right_cue_time_d) : (right_cue_time_d - left_cue_time_d);
				if (left_cue_valid_d && right_cue_valid_d &&
					cue_gap <= {16'd0, cfg.max_cue_spread}) begin
					cue_latched_d = 1'b1;
					go_init       = 1'b1;
				end
				if (!go_init && item.met_ms > {8'd0, cfg.backup_cue_time}) begin
					go_init = 1'b1;
				end
			end

			// Initiation: set deadlines once, then wait for them.
			if (go_init) begin
				init_latched_d = 1'b1;
				if (!deadlines_set_q) begin
					deadlines_set_d    = 1'b1;
					moding_deadline_d  = moding_sat;
					command_deadline_d = command_sat;
				end
				if (item.met_ms >= moding_eff) begin
					pyro = 1'b1;
					if (item.met_ms >= command_eff) begin
						go_check = 1'b1;
					end
				end
			end

			// Separation condition check with manual override.
			if (go_check) begin
				alert_latched_d = 1'b0;
				if (item.manual_enable && item.manual_initiate) begin
					go_fire = 1'b1;
				end else if (limits_ok) begin
					go_fire = 1'b1;
				end else begin
					alert_latched_d = 1'b1;
				end
			end

			// Fire, unless MECO is confirmed, and run the hold.
			if (go_fire && !item.meco_confirmed) begin
				fire          = 1'b1;
				cmd_latched_d = 1'b1;
				if (!fire_started_q) begin
					fire_started_d    = 1'b1;
					fire_start_time_d = item.met_ms;
					req103            = 1'b1;
				end
				hold_age = item.met_ms - fire_start_time_d;
				if (item.met_ms >= fire_start_time_d && hold_age >= HOLD_MS) begin
					if (!hold_passed_q) begin
						hold_passed_d = 1'b1;
					end else begin
						mreset  = 1'b1;
						armed_d = 1'b0;
					end
				end
			end
		end

		res.seq_active       = armed_d;
		res.pc_cue_flag      = cue_latched_d;
		res.initiated        = init_latched_d;
		res.pyro_arm         = pyro;
		res.inhibit_alert    = alert_latched_d;
		res.fire             = fire;
		res.sep_commanded    = cmd_latched_d;
		res.mode_103_request = req103;
		res.master_reset     = mreset;
		res.mode_accepted    = accepted;
	end

	// State update when an item moves through the step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q            <= 1'b0;
			init_latched_q     <= 1'b0;
			cmd_latched_q      <= 1'b0;
			cue_latched_q      <= 1'b0;
			alert_latched_q    <= 1'b0;
			left_cue_valid_q   <= 1'b0;
			right_cue_valid_q  <= 1'b0;
			deadlines_set_q    <= 1'b0;
			fire_started_q     <= 1'b0;
			hold_passed_q      <= 1'b0;
			left_cue_time_q    <= 32'd0;
			right_cue_time_q   <= 32'd0;
			moding_deadline_q  <= 32'd0;
			command_deadline_q <= 32'd0;
			fire_start_time_q  <= 32'd0;
		end else if (step_en) begin
			armed_q            <= armed_d;
			init_latched_q     <= init_latched_d;
			cmd_latched_q      <= cmd_latched_d;
			cue_latched_q      <= cue_latched_d;
			alert_latched_q    <= alert_latched_d;
			left_cue_valid_q   <= left_cue_valid_d;
			right_cue_valid_q  <= right_cue_valid_d;
			deadlines_set_q    <= deadlines_set_d;
			fire_started_q     <= fire_started_d;
			hold_passed_q      <= hold_passed_d;
			left_cue_time_q    <= left_cue_time_d;
			right_cue_time_q   <= right_cue_time_d;
			moding_deadline_q  <= moding_deadline_d;
			command_deadline_q <= command_deadline_d;
			fire_start_time_q  <= fire_start_time_d;
		end
	end

	// The master reset pulse disarms the sequence.
	a_reset_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.master_reset |=> !armed_q)
		else $error("sequence still armed after master reset");

	// Once the fire time is captured it is never released.
	a_fire_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire_started_q |=> fire_started_q)
		else $error("fire start flag dropped");

	// The mode 103 request marks the first fire.
	a_req_first: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.mode_103_request |-> !fire_started_q ##1 fire_started_q && cmd_latched_q)
		else $error("mode 103 request outside the first fire");

	// Pyro arm only comes with initiation latched.
	a_pyro_init: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.pyro_arm |=> init_latched_q && deadlines_set_q)
		else $error("pyro arm without initiation");

endmodule

### src/booster_separation_sequencer.sv
// Top level of the booster separation sequencer: handshakes, item and result registers.
//
// Each item is taken into an input register, passes the sequencing logic and
// lands in a result register, so the block takes one item per clock cycle while
// the result side does not stall. The result is shown from the result register
// once the item has left the input register.
// The result register lets a new item enter while a finished result waits to be
// taken. The sequence state is updated as an item leaves the input register, so
// the next item always sees it. Configuration writes are taken in every cycle
// and should only be made while no item is in flight.
module booster_separation_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bsep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsep_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Input item channel.
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [9:0]                         new_major_mode,
	input  logic [31:0]                        met_ms,
	input  logic [9:0]                         left_chamber_psi,
	input  logic [9:0]                         right_chamber_psi,
	input  logic signed [15:0]                 roll_rate,
	input  logic signed [15:0]                 pitch_rate,
	input  logic signed [15:0]                 yaw_rate,
	input  logic [15:0]                        dyn_pressure_pa,
	input  logic                               manual_enable,
	input  logic                               manual_initiate,
	input  logic                               meco_confirmed,
	// Result item channel.
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               seq_active,
	output logic                               pc_cue_flag,
	output logic                               initiated,
	output logic                               pyro_arm,
	output logic                               inhibit_alert,
	output logic                               fire,
	output logic                               sep_commanded,
	output logic                               mode_103_request,
	output logic                               master_reset,
	output logic                               mode_accepted
);
	import bsep_pkg::*;

	cfg_t    cfg;
	item_t   item_in, item_s1;
	logic    valid_s1;
	result_t step_res, res_q;
	logic    out_valid_q;
	logic    out_free, step_en;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	bsep_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: the step runs when the result register can take a result.
	assign out_free = !out_valid_q || out_ready;
	assign step_en  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || step_en;

	assign item_in = '{
		action:            action,
		new_major_mode:    new_major_mode,
		met_ms:            met_ms,
		left_chamber_psi:  left_chamber_psi,
		right_chamber_psi: right_chamber_psi,
		roll_rate:         roll_rate,
		pitch_rate:        pitch_rate,
		yaw_rate:          yaw_rate,
		dyn_pressure_pa:   dyn_pressure_pa,
		manual_enable:     manual_enable,
		manual_initiate:   manual_initiate,
		meco_confirmed:    meco_confirmed
	};

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

	// Sequencing logic and state.
	bsep_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (step_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= step_res;
		end
	end

	assign out_valid        = out_valid_q;
	assign seq_active       = res_q.seq_active;
	assign pc_cue_flag      = res_q.pc_cue_flag;
	assign initiated        = res_q.initiated;
	assign pyro_arm         = res_q.pyro_arm;
	assign inhibit_alert    = res_q.inhibit_alert;
	assign fire             = res_q.fire;
	assign sep_commanded    = res_q.sep_commanded;
	assign mode_103_request = res_q.mode_103_request;
	assign master_reset     = res_q.master_reset;
	assign mode_accepted    = res_q.mode_accepted;

endmodule

### sim/booster_separation_sequencer_test.sv
// Self-checking testbench for the booster separation sequencer with a flag predictor.
`timescale 1ns / 100ps

module booster_separation_sequencer_test;
	import bsep_pkg::*;

	localparam int PHASE_ITEMS = 325;
	localparam int PHASES      = 6;
	localparam int QUIET_LIMIT = 1000;

	typedef enum logic [1:0] {STG_NONE, STG_INIT, STG_CHECK, STG_FIRE} stage_t;

	// Predicts the result flags of every accepted item and checks the block's results.
	class sequencer_scoreboard;
		cfg_t        cfg;
		result_t     due_flags[$];
		int          errors;
		int          live_items;
		int          results_seen;
		string       flag_names[10] = '{"seq_active", "pc_cue_flag", "initiated", "pyro_arm",
			"inhibit_alert", "fire", "sep_commanded", "mode_103_request", "master_reset",
			"mode_accepted"};
		// Sequence state.
		logic        seq_armed, init_done, cmd_done, cue_seen, alert_on;
		logic        left_low, right_low, timers_set, fire_seen, hold_done;
		logic [31:0] left_ms, right_ms, null_ms, check_ms, fire_ms;

		function new();
			cfg.roll_rate_limit  = 24'd9999900;
			cfg.pitch_rate_limit = 24'd9999900;
			cfg.yaw_rate_limit   = 24'd9999900;
			cfg.qbar_limit       = 17'd99999;
			cfg.backup_cue_time  = 24'd131280;
			cfg.moding_delay     = 16'd3200;
			cfg.command_delay    = 16'd4900;
			cfg.max_cue_spread   = 16'd5500;
			{seq_armed, init_done, cmd_done, cue_seen, alert_on} = '0;
			{left_low, right_low, timers_set, fire_seen, hold_done} = '0;
			{left_ms, right_ms, null_ms, check_ms, fire_ms} = '0;
			errors = 0;
			live_items = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ROLL_LIMIT:  cfg.roll_rate_limit  = data;
				CFG_PITCH_LIMIT: cfg.pitch_rate_limit = data;
				CFG_YAW_LIMIT:   cfg.yaw_rate_limit   = data;
				CFG_QBAR_LIMIT:  cfg.qbar_limit       = data[16:0];
				CFG_BACKUP_CUE:  cfg.backup_cue_time  = data;
				CFG_MODING_DLY:  cfg.moding_delay     = data[15:0];
				CFG_COMMAND_DLY: cfg.command_delay    = data[15:0];
				CFG_CUE_SPREAD:  cfg.max_cue_spread   = data[15:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {17'd0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function logic [16:0] rate_abs(logic [15:0] v);
			return v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
		endfunction

		// Runs one item through the sequence and queues the flags it must produce.
		function void take_item(item_t it);
			stage_t          stg;
			logic [31:0]     met, spread;
			logic            pyro, fire_now, req, mreset, acc;
			longint unsigned q, lim;
			met = it.met_ms;
			stg = STG_NONE;
			{pyro, fire_now, req, mreset, acc} = '0;
			if (it.action || (seq_armed && met >= START_MS))
				live_items++;
			if (it.action) begin
				if (it.new_major_mode == MODE_ARM) begin
					seq_armed = 1'b1;
					acc = 1'b1;
				end else if (it.new_major_mode == MODE_NEXT) begin
					acc = 1'b1;
				end
			end else if (seq_armed && met >= START_MS) begin
				if (cmd_done) begin
					stg = STG_FIRE;
				end else if (init_done) begin
					stg = STG_INIT;
				end else begin
					// Latch the first low-pressure time on each side.
					if (it.left_chamber_psi < CUE_PSI && !left_low) begin
						left_low = 1'b1;
						left_ms = met;
					end
					if (it.right_chamber_psi < CUE_PSI && !right_low) begin
						right_low = 1'b1;
						right_ms = met;
					end
					if (left_low && right_low) begin
						spread = (left_ms >= right_ms) ? left_ms - right_ms : right_ms - left_ms;
						if (spread <= {16'd0, cfg.max_cue_spread}) begin
							cue_seen = 1'b1;
							stg = STG_INIT;
						end
					end
					if (stg == STG_NONE && met > {8'd0, cfg.backup_cue_time})
						stg = STG_INIT;
				end

				// Initiation: deadlines are set once, then pyro arm and the check follow.
				if (stg == STG_INIT) begin
					init_done = 1'b1;
					if (!timers_set) begin
						timers_set = 1'b1;
						null_ms = sat_add(met, cfg.moding_delay);
						check_ms = sat_add(met, cfg.command_delay);
					end
					if (met >= null_ms) begin
						pyro = 1'b1;
						if (met >= check_ms)
							stg = STG_CHECK;
					end
				end

				// Rate and dynamic pressure check with the crew override.
				if (stg == STG_CHECK) begin
					alert_on = 1'b0;
					if (it.manual_enable && it.manual_initiate) begin
						stg = STG_FIRE;
					end else begin
						q = 64'(it.dyn_pressure_pa) * 64'(QBAR_Q16);
						lim = 64'(cfg.qbar_limit) << 16;
						if (rate_abs(it.roll_rate) < cfg.roll_rate_limit &&
							rate_abs(it.pitch_rate) < cfg.pitch_rate_limit &&
							rate_abs(it.yaw_rate) < cfg.yaw_rate_limit && q < lim)
							stg = STG_FIRE;
						else
							alert_on = 1'b1;
					end
				end

				// Fire unless MECO is confirmed; the hold ends the sequence.
				if (stg == STG_FIRE && !it.meco_confirmed) begin
					fire_now = 1'b1;
					cmd_done = 1'b1;
					if (!fire_seen) begin
						fire_seen = 1'b1;
						fire_ms = met;
						req = 1'b1;
					end
					if (met >= fire_ms && met - fire_ms >= HOLD_MS) begin
						if (!hold_done) begin
							hold_done = 1'b1;
						end else begin
							mreset = 1'b1;
							seq_armed = 1'b0;
						end
					end
				end
			end
			due_flags.push_back({seq_armed, cue_seen, init_done, pyro, alert_on, fire_now,
				cmd_done, req, mreset, acc});
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		// Compares one result from the block with the oldest expectation.
		task check_flags(result_t got);
			result_t want;
			if (due_flags.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", results_seen));
			end else begin
				want = due_flags.pop_front();
				for (int i = 0; i < $bits(result_t); i++) begin
					if (got[$bits(result_t) - 1 - i] !== want[$bits(result_t) - 1 - i])
						report($sformatf("result %0d %s got %b want %b", results_seen,
							flag_names[i], got[$bits(result_t) - 1 - i],
							want[$bits(result_t) - 1 - i]));
				end
			end
			results_seen++;
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  action;
	logic [9:0]            new_major_mode;
	logic [31:0]           met_ms;
	logic [9:0]            left_chamber_psi;
	logic [9:0]            right_chamber_psi;
	logic signed [15:0]    roll_rate;
	logic signed [15:0]    pitch_rate;
	logic signed [15:0]    yaw_rate;
	logic [15:0]           dyn_pressure_pa;
	logic                  manual_enable;
	logic                  manual_initiate;
	logic                  meco_confirmed;
	logic                  out_valid;
	logic                  out_ready;
	logic                  seq_active;
	logic                  pc_cue_flag;
	logic                  initiated;
	logic                  pyro_arm;
	logic                  inhibit_alert;
	logic                  fire;
	logic                  sep_commanded;
	logic                  mode_103_request;
	logic                  master_reset;
	logic                  mode_accepted;

	sequencer_scoreboard sb;
	logic [31:0]         cur_met;
	bit                  feed_burst = 1'b0;
	bit                  sink_burst = 1'b0;
	int                  quiet = 0;

	booster_separation_sequencer dut (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both channels at the edge and hand accepted items to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_item({action, new_major_mode, met_ms, left_chamber_psi,
					right_chamber_psi, roll_rate, pitch_rate, yaw_rate, dyn_pressure_pa,
					manual_enable, manual_initiate, meco_confirmed});
			if (out_valid && out_ready)
				sb.check_flags({seq_active, pc_cue_flag, initiated, pyro_arm, inhibit_alert,
					fire, sep_commanded, mode_103_request, master_reset, mode_accepted});
		end
	end

	// Watchdog: end the run when no handshake happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Result side: random stalls, bursts without stalls, and one long hold-off.
	initial begin : result_sink
		int stall;
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && sb.results_seen >= 400) begin
				held = 1'b1;
				stall = 120;
			end else begin
				stall = sink_burst ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if ($urandom_range(0, 63) == 0)
				sink_burst = !sink_burst;
		end
	end

	// Offers one item after a random gap, none in a burst, and holds it until accepted.
	task automatic send_item(input item_t it);
		int gap;
		gap = feed_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action            <= it.action;
		new_major_mode    <= it.new_major_mode;
		met_ms            <= it.met_ms;
		left_chamber_psi  <= it.left_chamber_psi;
		right_chamber_psi <= it.right_chamber_psi;
		roll_rate         <= it.roll_rate;
		pitch_rate        <= it.pitch_rate;
		yaw_rate          <= it.yaw_rate;
		dyn_pressure_pa   <= it.dyn_pressure_pa;
		manual_enable     <= it.manual_enable;
		manual_initiate   <= it.manual_initiate;
		meco_confirmed    <= it.meco_confirmed;
		in_valid          <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if ($urandom_range(0, 63) == 0)
			feed_burst = !feed_burst;
	endtask

	// Stops the input side and waits until every expected result has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_flags.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register; the caller lowers the valid after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Loads all registers: all ones, all zeros, or random values, some with junk upper bits.
	task automatic write_config(input int phase);
		logic [CFG_DATA_W-1:0] rates[3];
		logic [CFG_DATA_W-1:0] qbar, backup, mdly, cdly, spread;
		longint unsigned       b;
		if (phase == 2 || phase == 4) begin
			for (int i = 0; i < 3; i++)
				rates[i] = (phase == 2) ? '1 : '0;
			qbar = rates[0];
			backup = rates[0];
			mdly = rates[0];
			cdly = rates[0];
			spread = rates[0];
		end else begin
			for (int i = 0; i < 3; i++)
				rates[i] = 24'($urandom_range(0, 40000));
			qbar = {7'($urandom), 17'($urandom_range(0, 1500))};
			b = 64'(cur_met) + 64'($urandom_range(0, 60000));
			backup = (b > 64'hFF_FFFF) ? 24'hFF_FFFF : 24'(b);
			mdly = {8'($urandom), 16'($urandom_range(0, 8000))};
			cdly = {8'($urandom), 16'($urandom_range(0, 8000))};
			spread = {8'($urandom), 16'($urandom_range(0, 8000))};
		end
		write_reg(CFG_ROLL_LIMIT, rates[0]);
		write_reg(CFG_PITCH_LIMIT, rates[1]);
		write_reg(CFG_YAW_LIMIT, rates[2]);
		write_reg(CFG_QBAR_LIMIT, qbar);
		write_reg(CFG_BACKUP_CUE, backup);
		write_reg(CFG_MODING_DLY, mdly);
		write_reg(CFG_COMMAND_DLY, cdly);
		write_reg(CFG_CUE_SPREAD, spread);
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t tick_item(logic [31:0] met, logic [9:0] lpsi, logic [9:0] rpsi);
		item_t it;
		it = '0;
		it.met_ms = met;
		it.left_chamber_psi = lpsi;
		it.right_chamber_psi = rpsi;
		return it;
	endfunction

	function automatic item_t mode_item(logic [9:0] mode);
		item_t it;
		it = '0;
		it.action = 1'b1;
		it.new_major_mode = mode;
		return it;
	endfunction

	// Next random item: mostly a well-formed flight timeline with random content,
	// plus mode changes and a little timing noise.
	function automatic item_t next_item(int phase);
		item_t       it;
		int unsigned step;
		int unsigned noise_pct;
		it.action = 1'b0;
		it.new_major_mode = 10'($urandom_range(0, 999));
		it.met_ms = $urandom;
		it.left_chamber_psi = 10'($urandom);
		it.right_chamber_psi = 10'($urandom);
		it.roll_rate = 16'($urandom);
		it.pitch_rate = 16'($urandom);
		it.yaw_rate = 16'($urandom);
		it.dyn_pressure_pa = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4000))
			: 16'($urandom);
		it.manual_enable = ($urandom_range(0, 2) == 0);
		it.manual_initiate = ($urandom_range(0, 2) == 0);
		it.meco_confirmed = ($urandom_range(0, 99) < ((phase < 3) ? 85 : 35));
		if ($urandom_range(0, 99) < (sb.seq_armed ? 3 : 30)) begin
			it.action = 1'b1;
			case ($urandom_range(0, 3))
				0, 1: it.new_major_mode = MODE_ARM;
				2: it.new_major_mode = MODE_NEXT;
				default: ;
			endcase
		end else begin
			// Before initiation the pressures rarely drop below the cue level.
			if (!sb.init_done) begin
				it.left_chamber_psi = ($urandom_range(0, 99) < 4) ?
					10'($urandom_range(0, 49)) : 10'($urandom_range(50, 1023));
				it.right_chamber_psi = ($urandom_range(0, 99) < 4) ?
					10'($urandom_range(0, 49)) : 10'($urandom_range(50, 1023));
			end
			step = $urandom_range(0, 300);
			cur_met = (cur_met > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : cur_met + step;
			it.met_ms = cur_met;
			// Timing noise; far jumps only where they cannot stall the timeline.
			noise_pct = $urandom_range(0, 99);
			if (noise_pct < 3) begin
				case ($urandom_range(0, 3))
					0: it.met_ms = $urandom_range(0, START_MS - 1);
					1: it.met_ms = cur_met - 32'($urandom_range(0, 20000));
					2: if (sb.cmd_done || !sb.seq_armed) it.met_ms = $urandom;
					default: if (sb.cmd_done || !sb.seq_armed)
						it.met_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 70000));
				endcase
			end
		end
		return it;
	endfunction

	// Main stimulus.
	initial begin : stimulus
		item_t it;
		int    guard;
		sb = new();
		arst_n            <= 1'b0;
		cfg_valid         <= 1'b0;
		cfg_index         <= '0;
		cfg_data          <= '0;
		in_valid          <= 1'b0;
		action            <= 1'b0;
		new_major_mode    <= '0;
		met_ms            <= '0;
		left_chamber_psi  <= '0;
		right_chamber_psi <= '0;
		roll_rate         <= '0;
		pitch_rate        <= '0;
		yaw_rate          <= '0;
		dyn_pressure_pa   <= '0;
		manual_enable     <= 1'b0;
		manual_initiate   <= 1'b0;
		meco_confirmed    <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unarmed ticks with field extremes change nothing.
		send_item(tick_item('0, '0, '0));
		it = '1;
		it.action = 1'b0;
		it.new_major_mode = 10'd999;
		send_item(it);
		it = tick_item(START_MS, '0, '0);
		it.roll_rate = 16'sh8000;
		it.pitch_rate = 16'sh7FFF;
		it.yaw_rate = 16'sh8000;
		it.dyn_pressure_pa = 16'hFFFF;
		it.meco_confirmed = 1'b1;
		send_item(it);
		// Mode changes: only the arming mode and the next mode are accepted.
		send_item(mode_item(10'd0));
		send_item(mode_item(10'd999));
		send_item(mode_item(MODE_NEXT));
		send_item(mode_item(MODE_ARM - 10'd1));
		send_item(mode_item(MODE_ARM));
		// Armed but early ticks are ignored.
		send_item(tick_item(START_MS - 32'd1, '0, '0));
		it = '1;
		it.action = 1'b0;
		it.met_ms = '0;
		it.new_major_mode = 10'd999;
		send_item(it);
		send_item(mode_item(MODE_NEXT));
		send_item(mode_item(MODE_ARM));
		// First live tick: exactly at the cue level gives no cue, just below does.
		send_item(tick_item(START_MS, CUE_PSI, CUE_PSI));
		send_item(tick_item(START_MS + 32'd1, CUE_PSI - 10'd1, 10'd1023));

		// Random timeline, in phases with different register settings.
		cur_met = ($urandom_range(0, 3) == 0) ?
			32'hFFFF_FFFF - 32'($urandom_range(50000, 200000)) : 32'd99000;
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain();
				write_config(phase);
			end
			guard = 0;
			while (sb.live_items < (phase + 1) * PHASE_ITEMS && guard < 4 * PHASE_ITEMS) begin
				send_item(next_item(phase));
				guard++;
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
